// ----- rtl/core/xoodoo_permutation_core_defines.svh -----
// Assertion macros for the Xoodoo permutation core.
// Used by xoodoo_permutation_core.sv; needs signals clk and rst in scope.
`ifndef XOODOO_PERMUTATION_CORE_DEFINES_SVH
`define XOODOO_PERMUTATION_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define XOO_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define XOO_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/xoo_pkg.sv -----
// Package for the Xoodoo permutation core: state types, round constants,
// and the single-round function. No dependencies.
package xoo_pkg;

  localparam int PLANES     = 3;
  localparam int SHEETS     = 4;
  localparam int LANE_W     = 32;
  localparam int MAX_ROUNDS = 12;
  localparam int ROUNDS_W   = 4;

  typedef logic [LANE_W-1:0] lane_t;
  typedef logic [PLANES-1:0][SHEETS-1:0][LANE_W-1:0] state_t;
  typedef logic [ROUNDS_W-1:0] rounds_t;

  // Control traveling alongside each state through the pipe.
  typedef struct packed {
    logic    valid;
    rounds_t rounds;
  } stage_ctl_t;

  localparam rounds_t MAX_ROUNDS_CODE = rounds_t'(MAX_ROUNDS);

  localparam lane_t RC [MAX_ROUNDS] = '{
    32'h0000_0058, 32'h0000_0038, 32'h0000_03C0, 32'h0000_00D0,
    32'h0000_0120, 32'h0000_0014, 32'h0000_0060, 32'h0000_002C,
    32'h0000_0380, 32'h0000_00F0, 32'h0000_01A0, 32'h0000_0012
  };

  // Rotate left by a constant, 0 < s < LANE_W.
  function automatic lane_t rotl(input lane_t v, input int s);
    return (v << s) | (v >> (LANE_W - s));
  endfunction

  // One full round: theta, rho-west, iota, chi, rho-east.
  function automatic state_t xoo_round(input state_t a, input lane_t rc);
    lane_t  p [SHEETS];
    lane_t  e [SHEETS];
    state_t m;
    state_t t;
    state_t b;
    state_t r;
    for (int x = 0; x < SHEETS; x++) begin
      p[x] = a[0][x] ^ a[1][x] ^ a[2][x];
    end
    for (int x = 0; x < SHEETS; x++) begin
      e[x] = rotl(p[(x + SHEETS - 1) % SHEETS], 5) ^ rotl(p[(x + SHEETS - 1) % SHEETS], 14);
    end
    for (int y = 0; y < PLANES; y++) begin
      for (int x = 0; x < SHEETS; x++) begin
        m[y][x] = a[y][x] ^ e[x];
      end
    end
    for (int x = 0; x < SHEETS; x++) begin
      t[0][x] = m[0][x];
      t[1][x] = m[1][(x + SHEETS - 1) % SHEETS];
      t[2][x] = rotl(m[2][x], 11);
    end
    t[0][0] = t[0][0] ^ rc;
    for (int y = 0; y < PLANES; y++) begin
      for (int x = 0; x < SHEETS; x++) begin
        b[y][x] = t[y][x] ^ (~t[(y + 1) % PLANES][x] & t[(y + 2) % PLANES][x]);
      end
    end
    for (int x = 0; x < SHEETS; x++) begin
      r[0][x] = b[0][x];
      r[1][x] = rotl(b[1][x], 1);
      r[2][x] = rotl(b[2][(x + SHEETS - 2) % SHEETS], 8);
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/xoo_stage.sv -----
// One pipeline stage of the Xoodoo core: applies round RoundIdx when the
// item asks for more than RoundIdx rounds, else passes the state. Uses xoo_pkg.
module xoo_stage #(
  parameter int RoundIdx = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  xoo_pkg::stage_ctl_t up_ctl,
  input  xoo_pkg::state_t     up_state,
  output logic                ready,
  input  logic                down_ready,
  output xoo_pkg::stage_ctl_t ctl,
  output xoo_pkg::state_t     state
);
  import xoo_pkg::*;

  localparam rounds_t ROUND_CODE = rounds_t'(RoundIdx);

  logic   apply;
  state_t state_next;

  assign ready      = !ctl.valid || down_ready;
  assign apply      = ROUND_CODE < up_ctl.rounds;
  assign state_next = apply ? xoo_round(up_state, RC[RoundIdx]) : up_state;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.valid <= 1'b0;
    end else begin
      if (ready) begin
        ctl.valid <= up_ctl.valid;
      end
      if (ready && up_ctl.valid) begin
        ctl.rounds <= up_ctl.rounds;
        state      <= state_next;
      end
    end
  end

endmodule

// ----- rtl/core/xoodoo_permutation_core.sv -----
// Xoodoo-384 permutation core, top level.
// Instantiates twelve xoo_stage round stages; uses xoo_pkg and the defines header.
//
// Usage:
//   Input channel: in_valid / in_stall with twelve 32-bit lanes in_pY_sX.
//   A transfer happens on a rising edge with in_valid high and in_stall low.
//   Output channel: out_valid / out_stall with lanes out_pY_sX, same rule.
//   Config channel: cfg_valid / cfg_ready / cfg_data sets num_rounds (reset 12);
//   cfg_ready is always high. Values above 12 run 12 rounds, 0 passes the
//   state through. Write it only while the pipe is empty.
//   Pipeline: twelve register stages, one round per stage. Every item passes
//   through all of them before out_valid shows it, regardless of num_rounds.
//   Throughput: one state per cycle while out_stall is low.
//   The round count is sampled at input transfer and travels with the item.
//   Reset (rst, synchronous) empties the pipe and restores num_rounds = 12.
//   When out_stall is high, filled stages hold; empty slots ahead still close
//   up, so input transfers continue until all twelve stages are full, then
//   in_stall rises. No item is dropped or repeated.
`include "xoodoo_permutation_core_defines.svh"

module xoodoo_permutation_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  xoo_pkg::rounds_t     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  xoo_pkg::lane_t       in_p0_s0,
  input  xoo_pkg::lane_t       in_p0_s1,
  input  xoo_pkg::lane_t       in_p0_s2,
  input  xoo_pkg::lane_t       in_p0_s3,
  input  xoo_pkg::lane_t       in_p1_s0,
  input  xoo_pkg::lane_t       in_p1_s1,
  input  xoo_pkg::lane_t       in_p1_s2,
  input  xoo_pkg::lane_t       in_p1_s3,
  input  xoo_pkg::lane_t       in_p2_s0,
  input  xoo_pkg::lane_t       in_p2_s1,
  input  xoo_pkg::lane_t       in_p2_s2,
  input  xoo_pkg::lane_t       in_p2_s3,
  output logic                 out_valid,
  input  logic                 out_stall,
  output xoo_pkg::lane_t       out_p0_s0,
  output xoo_pkg::lane_t       out_p0_s1,
  output xoo_pkg::lane_t       out_p0_s2,
  output xoo_pkg::lane_t       out_p0_s3,
  output xoo_pkg::lane_t       out_p1_s0,
  output xoo_pkg::lane_t       out_p1_s1,
  output xoo_pkg::lane_t       out_p1_s2,
  output xoo_pkg::lane_t       out_p1_s3,
  output xoo_pkg::lane_t       out_p2_s0,
  output xoo_pkg::lane_t       out_p2_s1,
  output xoo_pkg::lane_t       out_p2_s2,
  output xoo_pkg::lane_t       out_p2_s3
);
  import xoo_pkg::*;

  // Round-count register; always writable.
  rounds_t num_rounds;
  rounds_t rounds_sat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_rounds <= MAX_ROUNDS_CODE;
    end else if (cfg_valid && cfg_ready) begin
      num_rounds <= cfg_data;
    end
  end

  // Counts above the table length saturate.
  assign rounds_sat = (num_rounds > MAX_ROUNDS_CODE) ? MAX_ROUNDS_CODE : num_rounds;

  // Input packing into [plane][sheet].
  state_t     in_state;
  stage_ctl_t in_ctl;

  assign in_state[0][0] = in_p0_s0;
  assign in_state[0][1] = in_p0_s1;
  assign in_state[0][2] = in_p0_s2;
  assign in_state[0][3] = in_p0_s3;
  assign in_state[1][0] = in_p1_s0;
  assign in_state[1][1] = in_p1_s1;
  assign in_state[1][2] = in_p1_s2;
  assign in_state[1][3] = in_p1_s3;
  assign in_state[2][0] = in_p2_s0;
  assign in_state[2][1] = in_p2_s1;
  assign in_state[2][2] = in_p2_s2;
  assign in_state[2][3] = in_p2_s3;

  assign in_ctl.valid  = in_valid;
  assign in_ctl.rounds = rounds_sat;

  // Round pipeline: stage k holds the state after round k (or untouched).
  stage_ctl_t                  stg_ctl   [MAX_ROUNDS];
  state_t                      stg_state [MAX_ROUNDS];
  logic       [MAX_ROUNDS-1:0] stg_ready;
  logic       [MAX_ROUNDS-1:0] stg_valid;

  for (genvar k = 0; k < MAX_ROUNDS; k++) begin : g_stage
    stage_ctl_t up_ctl;
    state_t     up_state;
    logic       down_ready;

    if (k == 0) begin : g_first
      assign up_ctl   = in_ctl;
      assign up_state = in_state;
    end else begin : g_rest
      assign up_ctl   = stg_ctl[k-1];
      assign up_state = stg_state[k-1];
    end

    if (k == MAX_ROUNDS - 1) begin : g_last
      assign down_ready = !out_stall;
    end else begin : g_mid
      assign down_ready = stg_ready[k+1];
    end

    xoo_stage #(
      .RoundIdx (k)
    ) u_stage (
      .clk        (clk),
      .rst        (rst),
      .up_ctl     (up_ctl),
      .up_state   (up_state),
      .ready      (stg_ready[k]),
      .down_ready (down_ready),
      .ctl        (stg_ctl[k]),
      .state      (stg_state[k])
    );

    assign stg_valid[k] = stg_ctl[k].valid;
  end

  assign in_stall  = !stg_ready[0];
  assign out_valid = stg_ctl[MAX_ROUNDS-1].valid;

  assign out_p0_s0 = stg_state[MAX_ROUNDS-1][0][0];
  assign out_p0_s1 = stg_state[MAX_ROUNDS-1][0][1];
  assign out_p0_s2 = stg_state[MAX_ROUNDS-1][0][2];
  assign out_p0_s3 = stg_state[MAX_ROUNDS-1][0][3];
  assign out_p1_s0 = stg_state[MAX_ROUNDS-1][1][0];
  assign out_p1_s1 = stg_state[MAX_ROUNDS-1][1][1];
  assign out_p1_s2 = stg_state[MAX_ROUNDS-1][1][2];
  assign out_p1_s3 = stg_state[MAX_ROUNDS-1][1][3];
  assign out_p2_s0 = stg_state[MAX_ROUNDS-1][2][0];
  assign out_p2_s1 = stg_state[MAX_ROUNDS-1][2][1];
  assign out_p2_s2 = stg_state[MAX_ROUNDS-1][2][2];
  assign out_p2_s3 = stg_state[MAX_ROUNDS-1][2][3];

  // Back-pressure reaches the input only with every stage full.
  `XOO_ASSERT_NOW(a_stall_full, in_stall,
    out_valid && out_stall && ($countones(stg_valid) == MAX_ROUNDS),
    "input stalled while pipe has a free stage")

  // Round count carried by a live item in stage 0 never exceeds the table length.
  `XOO_ASSERT_NOW(a_rounds_cap, stg_ctl[0].valid,
    stg_ctl[0].rounds <= MAX_ROUNDS_CODE,
    "round count above cap entered the pipe")

  // A delivered result with nothing behind it leaves the output empty.
  `XOO_ASSERT_NEXT(a_drain, out_valid && !out_stall && !stg_valid[MAX_ROUNDS-2],
    !out_valid,
    "result repeated after transfer")

endmodule
